// ----- src/dtt_pkg.sv -----
// ----------------------------------------------------------------------------
// dtt_pkg: shared definitions for the dirty tile tracker
// Screen and tile geometry, index widths, opcodes and the command record
// passed from the front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // Screen geometry in pixels
  localparam int SCREEN_WIDTH  = 480;
  localparam int SCREEN_HEIGHT = 320;
  localparam int TILE_SIZE     = 32;

  // Tile grid, rounded up to cover partial tiles at the edges
  localparam int TILE_COLUMNS = (SCREEN_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
  localparam int TILE_ROWS    = (SCREEN_HEIGHT + TILE_SIZE - 1) / TILE_SIZE;
  localparam int TILE_COUNT   = TILE_COLUMNS * TILE_ROWS;

  // Index widths
  localparam int COL_W  = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
  localparam int ROW_W  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int TNUM_W = $clog2(TILE_COUNT) + 8;

  // Signed working width for rectangle arithmetic (16-bit fields plus sum)
  localparam int COORD_W = 18;

  // Command queue depth
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_MARK_ALL = 2'd1,
    OP_INVAL    = 2'd2,
    OP_POP      = 2'd3
  } op_t;

  typedef logic [TILE_COLUMNS-1:0] row_bits_t;

  // Classified command: tile row and column span for an invalidate
  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] r1;
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
  } cmd_t;

endpackage

// ----- src/dtt_front.sv -----
// ----------------------------------------------------------------------------
// dtt_front: input classification and rectangle clipping
// Accepts a transaction, drops rectangles that mark nothing, clips the rest
// to the screen and converts them to tile row and column spans.
// ----------------------------------------------------------------------------
module dtt_front
  import dtt_pkg::*;
(
  input  logic               push,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] rect_x,
  input  logic signed [15:0] rect_y,
  input  logic signed [15:0] rect_width,
  input  logic signed [15:0] rect_height,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               cmd
);

  localparam logic signed [COORD_W-1:0] SW_S   = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] SH_S   = COORD_W'(SCREEN_HEIGHT);
  localparam logic signed [COORD_W-1:0] ZERO_S = '0;
  localparam logic signed [COORD_W-1:0] ONE_S  = COORD_W'(1);

  logic signed [COORD_W-1:0] x_s, y_s, w_s, h_s;
  logic signed [COORD_W-1:0] right_s, bottom_s;
  logic signed [COORD_W-1:0] left_c, top_c, right_c, bottom_c;
  logic [COORD_W-1:0]        left_u, top_u, right_m1, bottom_m1;
  logic                      rect_none;
  logic                      accept;

  // Sign-extend the rectangle fields
  assign x_s = $signed({{(COORD_W-16){rect_x[15]}}, rect_x});
  assign y_s = $signed({{(COORD_W-16){rect_y[15]}}, rect_y});
  assign w_s = $signed({{(COORD_W-16){rect_width[15]}}, rect_width});
  assign h_s = $signed({{(COORD_W-16){rect_height[15]}}, rect_height});

  assign right_s  = x_s + w_s;
  assign bottom_s = y_s + h_s;

  // Empty or fully off-screen rectangles mark nothing
  assign rect_none = (w_s <= ZERO_S) || (h_s <= ZERO_S) ||
                     (x_s >= SW_S) || (y_s >= SH_S) ||
                     (right_s <= ZERO_S) || (bottom_s <= ZERO_S);

  // Clip to the screen
  always_comb begin
    left_c   = (x_s < ZERO_S) ? ZERO_S : x_s;
    top_c    = (y_s < ZERO_S) ? ZERO_S : y_s;
    right_c  = (right_s > SW_S) ? SW_S : right_s;
    bottom_c = (bottom_s > SH_S) ? SH_S : bottom_s;
  end

  assign left_u    = $unsigned(left_c);
  assign top_u     = $unsigned(top_c);
  assign right_m1  = $unsigned(right_c - ONE_S);
  assign bottom_m1 = $unsigned(bottom_c - ONE_S);

  // Build the command record
  always_comb begin
    cmd.op = op_t'(opcode);
    cmd.c0 = COL_W'(left_u / TILE_SIZE);
    cmd.c1 = COL_W'(right_m1 / TILE_SIZE);
    cmd.r0 = ROW_W'(top_u / TILE_SIZE);
    cmd.r1 = ROW_W'(bottom_m1 / TILE_SIZE);
  end

  // Forward every accepted transaction except rectangles that mark nothing
  assign accept = push && !q_full;
  assign q_push = accept && !((op_t'(opcode) == OP_INVAL) && rect_none);

endmodule

// ----- src/dtt_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// dtt_cmd_queue: command queue between front end and back end
// Small register-based FIFO of classified commands so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module dtt_cmd_queue
  import dtt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic full,
  output logic empty
);

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push, do_pop;

  assign full    = (count == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/dtt_back.sv -----
// ----------------------------------------------------------------------------
// dtt_back: dirty bitmap and command sequencer
// Holds one dirty bit per tile as row words. Clear/mark all act at once, the
// rest one row word per cycle; a pop waits for a free output result register.
// ----------------------------------------------------------------------------
module dtt_back
  import dtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_empty,
  input  cmd_t       cmd,
  output logic       cmd_take,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] tile_number,
  output logic       found
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_SCAN
  } state_t;

  state_t            state;
  row_bits_t         rows [TILE_ROWS];
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  mark_r1;
  row_bits_t         mark_mask;
  logic              out_valid;
  logic [7:0]        out_tile;
  logic              out_found;

  row_bits_t         cur;
  row_bits_t         cmd_mask;
  logic              cur_nz;
  logic              scan_end;
  logic              out_free;
  logic              out_load;
  logic [COL_W-1:0]  low_col;
  logic [TNUM_W-1:0] tile_full;
  logic              any_dirty;

  // Index of the lowest set bit of a row word
  function automatic logic [COL_W-1:0] lowest_set(row_bits_t v);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = TILE_COLUMNS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = COL_W'(i);
      end
    end
    return idx;
  endfunction

  // Column mask of an invalidate command
  always_comb begin
    for (int c = 0; c < TILE_COLUMNS; c++) begin
      cmd_mask[c] = (COL_W'(c) >= cmd.c0) && (COL_W'(c) <= cmd.c1);
    end
  end

  // Current row word and pop lookup
  assign cur       = rows[row];
  assign cur_nz    = |cur;
  assign low_col   = lowest_set(cur);
  assign tile_full = TNUM_W'(row) * TNUM_W'(TILE_COLUMNS) + TNUM_W'(low_col);
  assign scan_end  = (row == ROW_W'(TILE_ROWS - 1));
  assign out_free  = !out_valid || pop;
  assign out_load  = (state == S_SCAN) && out_free && (cur_nz || scan_end);
  assign cmd_take  = (state == S_IDLE) && !cmd_empty;

  always_comb begin
    any_dirty = 1'b0;
    for (int r = 0; r < TILE_ROWS; r++) begin
      any_dirty = any_dirty | (|rows[r]);
    end
  end

  // Sequencer, bitmap and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < TILE_ROWS; r++) begin
        rows[r] <= '0;
      end
    end else begin
      // Hold the result until it is taken, reload it as a scan ends
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            case (cmd.op)
              OP_CLEAR: begin
                for (int r = 0; r < TILE_ROWS; r++) begin
                  rows[r] <= '0;
                end
              end
              OP_MARK_ALL: begin
                for (int r = 0; r < TILE_ROWS; r++) begin
                  rows[r] <= '1;
                end
              end
              OP_INVAL: begin
                row       <= cmd.r0;
                mark_r1   <= cmd.r1;
                mark_mask <= cmd_mask;
                state     <= S_MARK;
              end
              OP_POP: begin
                row   <= '0;
                state <= S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        S_MARK: begin
          rows[row] <= cur | mark_mask;
          if (row == mark_r1) begin
            state <= S_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end
        S_SCAN: begin
          if (cur_nz) begin
            // Drop the lowest dirty bit and report it
            if (out_free) begin
              rows[row] <= cur & (cur - 1'b1);
              out_tile  <= tile_full[7:0];
              out_found <= 1'b1;
              state     <= S_IDLE;
            end
          end else if (scan_end) begin
            if (out_free) begin
              out_tile  <= '0;
              out_found <= 1'b0;
              state     <= S_IDLE;
            end
          end else begin
            row <= row + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty       = !out_valid;
  assign tile_number = out_tile;
  assign found       = out_found;

  // Row walk of an invalidate never passes its last row
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (row <= mark_r1))
    else $error("invalidate row walk passed its last row");

  // A new result only comes out of a scan
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_SCAN))
    else $error("result appeared without a scan");

  // Clear all leaves no dirty tile
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !cmd_empty && cmd.op == OP_CLEAR) |=> !any_dirty)
    else $error("dirty tile left after clear all");

endmodule

// ----- src/dirty_tile_tracker_top.sv -----
// Back end: clear all and mark all update the whole bitmap at once, an invalidate
// writes one row word per cycle over the tile rows it spans, and a pop scans one row
// word per cycle until it finds a dirty tile or reaches the last row of the 15 x 10 tiles;
// a pop then waits for a free result register. A new command is taken only while idle.
// Reset (synchronous, active high) clears the bitmap and command queue and empties the result register.
// ----------------------------------------------------------------------------
// dirty_tile_tracker_top: dirty tile bitmap tracker
// Front end classifies and clips transactions, a command queue decouples it
// from the back end, which updates the bitmap and returns popped tiles.
// ----------------------------------------------------------------------------
module dirty_tile_tracker_top
  import dtt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] rect_x,
  input  logic signed [15:0] rect_y,
  input  logic signed [15:0] rect_width,
  input  logic signed [15:0] rect_height,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         tile_number,
  output logic               found
);

  logic q_push;
  logic q_empty;
  logic q_take;
  cmd_t front_cmd;
  cmd_t back_cmd;

  // Classify and clip
  dtt_front u_front (
    .push        (push),
    .opcode      (opcode),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .q_full      (full),
    .q_push      (q_push),
    .cmd         (front_cmd)
  );

  // Decouple front and back
  dtt_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (front_cmd),
    .pop   (q_take),
    .dout  (back_cmd),
    .full  (full),
    .empty (q_empty)
  );

  // Execute commands on the bitmap
  dtt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (q_empty),
    .cmd         (back_cmd),
    .cmd_take    (q_take),
    .pop         (pop),
    .empty       (empty),
    .tile_number (tile_number),
    .found       (found)
  );

endmodule

// ----- verif/dirty_tile_tracker_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_tile_tracker_top_tb: self-checking bench for the dirty tile tracker
// Keeps a shadow tile bitmap that follows every accepted transaction and
// predicts each pop result. Directed corner cases come first, then random
// rectangles and pops. The sender works in bursts, and the receiver stalls on
// its own pattern. One long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module dirty_tile_tracker_top_tb;
  import dtt_pkg::*;

  localparam int MAX_REPORTED   = 10;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 4 * TILE_ROWS + 8;
  localparam int HOLD_AFTER     = 150;
  localparam int HOLD_CYCLES    = 600;

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [1:0]         opcode;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_width;
  logic signed [15:0] rect_height;
  logic               empty;
  logic               pop;
  logic [7:0]         tile_number;
  logic               found;

  typedef struct {
    logic [7:0] tile;
    logic       hit;
  } pop_result_t;

  // Shadow bitmap and queue of predicted pop results
  class tile_scoreboard;
    bit [TILE_COLUMNS-1:0] dirty [TILE_ROWS];
    pop_result_t           pending [$];
    int                    mismatches;
    int                    checked;

    function new();
      mismatches = 0;
      checked = 0;
      foreach (dirty[r]) dirty[r] = '0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTED) $display("tb: mismatch: %s", msg);
    endfunction

    // Mark every tile that the clipped rectangle touches
    function void mark_rect(int x, int y, int w, int h);
      int left, top, right, bottom, c0, c1, r0, r1;
      if (w <= 0 || h <= 0 || x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT ||
          x + w <= 0 || y + h <= 0) return;
      left   = (x < 0) ? 0 : x;
      top    = (y < 0) ? 0 : y;
      right  = (x + w > SCREEN_WIDTH) ? SCREEN_WIDTH : x + w;
      bottom = (y + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + h;
      c0 = left / TILE_SIZE;
      c1 = (right - 1) / TILE_SIZE;
      r0 = top / TILE_SIZE;
      r1 = (bottom - 1) / TILE_SIZE;
      for (int r = r0; r <= r1 && r < TILE_ROWS; r++) begin
        for (int c = c0; c <= c1 && c < TILE_COLUMNS; c++) begin
          dirty[r][c] = 1'b1;
        end
      end
    endfunction

    // Apply one accepted transaction; a pop queues its predicted result
    function void note_item(op_t op, int x, int y, int w, int h);
      pop_result_t res;
      case (op)
        OP_CLEAR: begin
          foreach (dirty[r]) dirty[r] = '0;
        end
        OP_MARK_ALL: begin
          foreach (dirty[r]) dirty[r] = '1;
        end
        OP_INVAL: begin
          mark_rect(x, y, w, h);
        end
        default: begin
          res.tile = 8'd0;
          res.hit  = 1'b0;
          for (int r = 0; r < TILE_ROWS && !res.hit; r++) begin
            for (int c = 0; c < TILE_COLUMNS && !res.hit; c++) begin
              if (dirty[r][c]) begin
                dirty[r][c] = 1'b0;
                res.tile = 8'((r * TILE_COLUMNS + c) & 8'hFF);
                res.hit  = 1'b1;
              end
            end
          end
          pending.push_back(res);
        end
      endcase
    endfunction

    // Compare one popped result against the oldest prediction
    function void check_result(logic [7:0] tile, logic hit);
      pop_result_t exp_res;
      checked++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result tile_number=%0d found=%0b", tile, hit));
        return;
      end
      exp_res = pending.pop_front();
      if (hit !== exp_res.hit)
        flag($sformatf("found: expected %0b, got %0b", exp_res.hit, hit));
      if (tile !== exp_res.tile)
        flag($sformatf("tile_number: expected %0d, got %0d", exp_res.tile, tile));
    endfunction
  endclass

  tile_scoreboard sb;

  dirty_tile_tracker_top dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .empty       (empty),
    .pop         (pop),
    .tile_number (tile_number),
    .found       (found)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one transaction and hold it until the block takes it
  task automatic send_item(op_t op, int x, int y, int w, int h);
    opcode      <= op;
    rect_x      <= 16'(x);
    rect_y      <= 16'(y);
    rect_width  <= 16'(w);
    rect_height <= 16'(h);
    push        <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(op, int'($signed(16'(x))), int'($signed(16'(y))),
                 int'($signed(16'(w))), int'($signed(16'(h))));
  endtask

  // Build one random transaction: mostly near-screen rectangles and pops
  task automatic send_random_item();
    int   sel;
    op_t  op;
    int   x, y, w, h;
    sel = $urandom_range(0, 99);
    x = $signed(16'($urandom));
    y = $signed(16'($urandom));
    w = $signed(16'($urandom));
    h = $signed(16'($urandom));
    if (sel < 4) op = OP_CLEAR;
    else if (sel < 8) op = OP_MARK_ALL;
    else if (sel < 52) op = OP_INVAL;
    else op = OP_POP;
    if (op == OP_INVAL && $urandom_range(0, 9) != 0) begin
      x = int'($urandom_range(0, SCREEN_WIDTH + 96)) - 64;
      y = int'($urandom_range(0, SCREEN_HEIGHT + 96)) - 64;
      w = int'($urandom_range(0, 208)) - 8;
      h = int'($urandom_range(0, 208)) - 8;
    end
    send_item(op, x, y, w, h);
  endtask

  // Stimulus
  initial begin
    int sent;
    int burst;
    int wait_cycles;
    sb          = new();
    rst         <= 1'b1;
    push        <= 1'b0;
    opcode      <= OP_CLEAR;
    rect_x      <= '0;
    rect_y      <= '0;
    rect_width  <= '0;
    rect_height <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corner cases
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_MARK_ALL, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_INVAL, -32768, -32768, 32767, 32767);
    send_item(OP_INVAL, 0, 0, 0, 10);
    send_item(OP_INVAL, 0, 0, 10, -32768);
    send_item(OP_INVAL, SCREEN_WIDTH, 0, 10, 10);
    send_item(OP_INVAL, 0, SCREEN_HEIGHT, 10, 10);
    send_item(OP_INVAL, -10, -10, 10, 10);
    send_item(OP_INVAL, 32767, 32767, 32767, 32767);
    send_item(OP_INVAL, -32768, 100, -1, 5);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_INVAL, -10, -10, 11, 11);
    send_item(OP_INVAL, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 1, 1);
    send_item(OP_INVAL, 440, 300, 32767, 32767);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0, 0);
    send_item(OP_MARK_ALL, 0, 0, 0, 0);
    send_item(OP_POP, -1, -1, -1, -1);

    // Random bursts with random gaps; an occasional long burst has no idling
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_random_item();
        sent++;
      end
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push <= 1'b0;

    // Drain outstanding results, then let the back end settle
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending.size() != 0)
      $display("tb: %0d expected results never arrived", sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: check each popped transaction and stall on a pattern of its own
  initial begin
    int  mode;
    int  mode_left;
    int  hold_left;
    bit  held;
    pop       <= 1'b0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) sb.check_result(tile_number, found);
      // Long hold-off once, so the block fills up and stalls its input
      if (!held && sb.checked >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= ($urandom_range(0, 1) == 0);
          2:       pop <= ($urandom_range(0, 3) == 0);
          default: pop <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

endmodule
